### hdl/stt_pkg.sv
// Shared types, codes and field widths of the software timer table.
package stt_pkg;

	// Field widths of the stream payloads
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned DELAY_W  = 31;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned TAG_W    = 16;
	localparam int unsigned POS_W    = 8;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned ACTIVE_W = 5;
	localparam int unsigned OP_W     = 2;

	localparam int unsigned IN_DATA_W  = 120;
	localparam int unsigned OUT_DATA_W = 24;

	// Repeat count that never runs down
	localparam logic [COUNT_W-1:0] ENDLESS = '1;

	// Operation codes
	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 2'd0,
		OP_ADD    = 2'd1,
		OP_DELETE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

	// One timer record as held in the entry memory
	typedef struct packed {
		logic [TIME_W-1:0]  due;
		logic [DELAY_W-1:0] period;
		logic [COUNT_W-1:0] remaining;
		logic [TAG_W-1:0]   tag;
	} entry_t;

endpackage

### hdl/stt_entry_ram.sv
// Timer record memory: one write port, one registered read port.
module stt_entry_ram #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  stt_pkg::entry_t wr_data,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_addr,
	output stt_pkg::entry_t rd_data
);

	stt_pkg::entry_t mem [DEPTH];

	// Write record
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read record, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hdl/stt_tag_buf.sv
// Buffer of tags fired during one tick, replayed after the table walk.
module stt_tag_buf #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [stt_pkg::TAG_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [AW-1:0]             rd_addr,
	output logic [stt_pkg::TAG_W-1:0] rd_data
);

	logic [stt_pkg::TAG_W-1:0] mem [DEPTH];

	// Store fired tag
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read tag, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### hdl/software_timer_table.sv
// Software timer table top level: command sequencer around the record memory.
//
// Usage:
//   Commands arrive on the s_axis channel, one beat each; s_axis_tuser is the
//   operation (tick, add, delete). Results leave on the m_axis channel;
//   m_axis_tuser flags a firing and m_axis_tlast marks the final result beat
//   of a command. A tick gives one beat per fired timer, in table order, or
//   one beat with no firing.
// Sequencing:
//   Add and unused codes: result loaded from S_RESP into the output register.
//   Delete at position p: the records after p are read and written back one
//   place lower. Tick: the walk reads one record per cycle from the record
//   memory and writes each kept record to the next kept slot; fired tags go
//   to the tag buffer and are replayed after the walk.
//   Commands are taken one at a time; the next one is taken while the last
//   result beat still waits in the output register.
// Reset:
//   arst_n empties the table at once; no clearing pass is needed.
// Stall:
//   When m_axis_tready is low the output register holds its beat and the
//   sequencer waits before loading the next one.
module software_timer_table #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// time_ms[31:0], delay_ms[62:32], repeat_count[94:63], event_tag[110:95],
	// entry_position[118:111], zero pad[119]
	input  logic [stt_pkg::IN_DATA_W-1:0] s_axis_tdata,
	// operation[1:0]
	input  logic [stt_pkg::OP_W-1:0]      s_axis_tuser,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// fired_tag[15:0], status[17:16], active_count[22:18], zero pad[23]
	output logic [stt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// fired[0]
	output logic                          m_axis_tuser,
	output logic                          m_axis_tlast
);

	localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned XW = ((CW > stt_pkg::POS_W) ? CW : stt_pkg::POS_W) + 1;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_WALK  = 6'b000010,
		S_SHIFT = 6'b000100,
		S_RESP  = 6'b001000,
		S_FETCH = 6'b010000,
		S_SEND  = 6'b100000
	} state_t;

	state_t state_q;

	// Input fields
	logic [stt_pkg::TIME_W-1:0]  in_time;
	logic [stt_pkg::DELAY_W-1:0] in_delay;
	logic [stt_pkg::COUNT_W-1:0] in_count;
	logic [stt_pkg::TAG_W-1:0]   in_tag;
	logic [stt_pkg::POS_W-1:0]   in_pos;
	stt_pkg::op_t                in_op;

	assign in_time  = s_axis_tdata[31:0];
	assign in_delay = s_axis_tdata[62:32];
	assign in_count = s_axis_tdata[94:63];
	assign in_tag   = s_axis_tdata[110:95];
	assign in_pos   = s_axis_tdata[118:111];
	assign in_op    = stt_pkg::op_t'(s_axis_tuser);

	// Control and working registers
	logic [CW-1:0]                count_q;
	logic [CW-1:0]                idx_q;
	logic [CW-1:0]                keep_q;
	logic [CW-1:0]                nfire_q;
	logic [CW-1:0]                rd_q;
	logic                         vld_s1;
	logic [stt_pkg::TIME_W-1:0]   now_q;
	logic [stt_pkg::STATUS_W-1:0] status_q;

	// Output register
	logic                         out_valid_q;
	logic                         out_fired_q;
	logic [stt_pkg::TAG_W-1:0]    out_tag_q;
	logic [stt_pkg::STATUS_W-1:0] out_status_q;
	logic [stt_pkg::ACTIVE_W-1:0] out_count_q;
	logic                         out_last_q;

	// Memory ports
	logic                      ram_wr_en;
	logic [AW-1:0]             ram_wr_addr;
	stt_pkg::entry_t           ram_wr_data;
	logic                      ram_rd_en;
	logic [AW-1:0]             ram_rd_addr;
	stt_pkg::entry_t           ram_rd_data;
	logic                      tb_wr_en;
	logic                      tb_rd_en;
	logic [AW-1:0]             tb_rd_addr;
	logic [stt_pkg::TAG_W-1:0] tb_rd_data;

	logic                      in_fire;
	logic                      out_free;
	logic                      add_full;
	logic                      del_bad;
	logic [XW-1:0]             pos_x;
	logic [XW-1:0]             pos_next;
	logic [XW-1:0]             cnt_x;
	logic                      rd_more;
	logic [CW-1:0]             rd_next;
	logic                      send_last;
	stt_pkg::entry_t           add_rec;

	// Walk datapath
	logic [stt_pkg::TIME_W-1:0]  walk_diff;
	logic                        walk_fire;
	logic                        walk_keep;
	stt_pkg::entry_t             walk_rec;

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;

	assign add_full = (count_q >= CW'(CAPACITY));
	assign pos_x    = XW'(in_pos);
	assign pos_next = pos_x + XW'(1);
	assign cnt_x    = XW'(count_q);
	assign del_bad  = (pos_x >= cnt_x);
	assign rd_more  = vld_s1 && (idx_q < count_q);
	assign rd_next  = rd_q + CW'(1);
	assign send_last = (rd_next == nfire_q);

	assign add_rec.due       = in_time + stt_pkg::TIME_W'(in_delay);
	assign add_rec.period    = in_delay;
	assign add_rec.remaining = in_count;
	assign add_rec.tag       = in_tag;

	// Fire, advance and count down one record
	always_comb begin
		walk_rec  = ram_rd_data;
		walk_diff = ram_rd_data.due - now_q;
		walk_fire = ((walk_diff == '0) || walk_diff[stt_pkg::TIME_W-1])
			&& (ram_rd_data.remaining != '0);
		if (walk_fire) begin
			walk_rec.due = ram_rd_data.due + stt_pkg::TIME_W'(ram_rd_data.period);
			if (ram_rd_data.remaining != stt_pkg::ENDLESS) begin
				walk_rec.remaining = ram_rd_data.remaining - stt_pkg::COUNT_W'(1);
			end
		end
		walk_keep = (walk_rec.remaining != '0);
	end

	// Steer memory ports
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = keep_q[AW-1:0];
		ram_wr_data = walk_rec;
		ram_rd_en   = 1'b0;
		ram_rd_addr = idx_q[AW-1:0];
		tb_wr_en    = 1'b0;
		tb_rd_en    = 1'b0;
		tb_rd_addr  = rd_next[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					case (in_op)
						stt_pkg::OP_TICK: begin
							ram_rd_en   = (count_q != '0);
							ram_rd_addr = '0;
						end
						stt_pkg::OP_ADD: begin
							ram_wr_en   = !add_full;
							ram_wr_addr = count_q[AW-1:0];
							ram_wr_data = add_rec;
						end
						stt_pkg::OP_DELETE: begin
							ram_rd_en   = !del_bad && (pos_next < cnt_x);
							ram_rd_addr = pos_next[AW-1:0];
						end
						default: begin
						end
					endcase
				end
			end
			S_WALK: begin
				ram_wr_en = vld_s1 && walk_keep;
				tb_wr_en  = vld_s1 && walk_fire;
				ram_rd_en = rd_more;
			end
			S_SHIFT: begin
				ram_wr_en   = vld_s1;
				ram_wr_data = ram_rd_data;
				ram_rd_en   = rd_more;
			end
			S_FETCH: begin
				tb_rd_en   = 1'b1;
				tb_rd_addr = '0;
			end
			S_SEND: begin
				tb_rd_en = out_free && !send_last;
			end
			default: begin
			end
		endcase
	end

	// Sequence commands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			keep_q  <= '0;
			nfire_q <= '0;
			rd_q    <= '0;
			vld_s1  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						case (in_op)
							stt_pkg::OP_TICK: begin
								idx_q   <= CW'(1);
								keep_q  <= '0;
								nfire_q <= '0;
								vld_s1  <= (count_q != '0);
								state_q <= (count_q != '0) ? S_WALK : S_RESP;
							end
							stt_pkg::OP_ADD: begin
								if (!add_full) begin
									count_q <= count_q + CW'(1);
								end
								state_q <= S_RESP;
							end
							stt_pkg::OP_DELETE: begin
								idx_q   <= CW'(pos_next + XW'(1));
								keep_q  <= CW'(pos_x);
								vld_s1  <= !del_bad && (pos_next < cnt_x);
								state_q <= del_bad ? S_RESP : S_SHIFT;
							end
							default: begin
								state_q <= S_RESP;
							end
						endcase
					end
				end
				S_WALK: begin
					if (vld_s1) begin
						if (walk_keep) begin
							keep_q <= keep_q + CW'(1);
						end
						if (walk_fire) begin
							nfire_q <= nfire_q + CW'(1);
						end
						idx_q  <= idx_q + CW'(1);
						vld_s1 <= rd_more;
					end else begin
						count_q <= keep_q;
						state_q <= (nfire_q == '0) ? S_RESP : S_FETCH;
					end
				end
				S_SHIFT: begin
					if (vld_s1) begin
						keep_q <= keep_q + CW'(1);
						idx_q  <= idx_q + CW'(1);
						vld_s1 <= rd_more;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_FETCH: begin
					rd_q    <= '0;
					state_q <= S_SEND;
				end
				S_SEND: begin
					if (out_free) begin
						rd_q <= rd_next;
						if (send_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Capture command payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			now_q <= in_time;
			if (in_op == stt_pkg::OP_ADD && add_full) begin
				status_q <= stt_pkg::ST_FULL;
			end else if (in_op == stt_pkg::OP_DELETE && del_bad) begin
				status_q <= stt_pkg::ST_RANGE;
			end else begin
				status_q <= stt_pkg::ST_OK;
			end
		end
	end

	// Hold result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_RESP || state_q == S_SEND) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load result payload
	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			out_fired_q  <= 1'b0;
			out_tag_q    <= '0;
			out_status_q <= status_q;
			out_count_q  <= stt_pkg::ACTIVE_W'(count_q);
			out_last_q   <= 1'b1;
		end else if (state_q == S_SEND && out_free) begin
			out_fired_q  <= 1'b1;
			out_tag_q    <= tb_rd_data;
			out_status_q <= stt_pkg::ST_OK;
			out_count_q  <= stt_pkg::ACTIVE_W'(count_q);
			out_last_q   <= send_last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_count_q, out_status_q, out_tag_q};
	assign m_axis_tuser  = out_fired_q;
	assign m_axis_tlast  = out_last_q;

	stt_entry_ram #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_entry_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	stt_tag_buf #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_tag_buf (
		.clk     (clk),
		.wr_en   (tb_wr_en),
		.wr_addr (nfire_q[AW-1:0]),
		.wr_data (ram_rd_data.tag),
		.rd_en   (tb_rd_en),
		.rd_addr (tb_rd_addr),
		.rd_data (tb_rd_data)
	);

endmodule

### dv/software_timer_table_tb.sv
// Self-checking stream testbench for the software timer table with a built-in table predictor.
`timescale 1ns / 1ps

module software_timer_table_tb;

	localparam int unsigned TIMER_SLOTS  = 16;
	localparam int unsigned RANDOM_ITEMS = 200;
	localparam int unsigned DRAIN_CYCLES = 40;

	// One command beat as the driver sends it
	typedef struct {
		stt_pkg::op_t                op;
		logic [stt_pkg::TIME_W-1:0]  now;
		logic [stt_pkg::DELAY_W-1:0] delay;
		logic [stt_pkg::COUNT_W-1:0] count;
		logic [stt_pkg::TAG_W-1:0]   tag;
		logic [stt_pkg::POS_W-1:0]   pos;
	} cmd_t;

	// One result beat as the table should report it
	typedef struct {
		logic                         fired;
		logic [stt_pkg::TAG_W-1:0]    tag;
		logic [stt_pkg::STATUS_W-1:0] status;
		logic [stt_pkg::ACTIVE_W-1:0] active;
		logic                         last;
	} report_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [stt_pkg::IN_DATA_W-1:0]    s_axis_tdata = '0;
	logic [stt_pkg::OP_W-1:0]         s_axis_tuser = stt_pkg::OP_TICK;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [stt_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
	logic                             m_axis_tuser;
	logic                             m_axis_tlast;

	cmd_t    cmd_q[$];
	report_t report_q[$];
	cmd_t    cur_cmd;
	report_t want_beat;
	int      mismatch_count = 0;
	int      burst_left = 1;
	int      gap_left = 0;
	int      stall_pct = 0;
	int      phase_left = 0;

	// Predictor copy of the timer table
	logic [stt_pkg::TIME_W-1:0]  timer_due    [TIMER_SLOTS];
	logic [stt_pkg::DELAY_W-1:0] timer_period [TIMER_SLOTS];
	logic [stt_pkg::COUNT_W-1:0] timer_left   [TIMER_SLOTS];
	logic [stt_pkg::TAG_W-1:0]   timer_tag    [TIMER_SLOTS];
	int                          timer_total = 0;

	software_timer_table #(
		.CAPACITY(TIMER_SLOTS)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
	endtask

	task automatic add_cmd(input stt_pkg::op_t op, input logic [stt_pkg::TIME_W-1:0] now,
			input logic [stt_pkg::DELAY_W-1:0] delay,
			input logic [stt_pkg::COUNT_W-1:0] count,
			input logic [stt_pkg::TAG_W-1:0] tag, input logic [stt_pkg::POS_W-1:0] pos);
		cmd_t c;
		c.op    = op;
		c.now   = now;
		c.delay = delay;
		c.count = count;
		c.tag   = tag;
		c.pos   = pos;
		cmd_q = {cmd_q, c};
	endtask

	// Apply one accepted command to the table copy and queue the beats it causes
	task automatic run_timer_command(input cmd_t c);
		report_t                    r;
		logic [stt_pkg::TIME_W-1:0] diff;
		logic [stt_pkg::TAG_W-1:0]  fired_tags [TIMER_SLOTS];
		int                         n_fired;
		int                         keep;
		r.fired  = 1'b0;
		r.tag    = '0;
		r.status = stt_pkg::ST_OK;
		r.active = '0;
		r.last   = 1'b1;
		n_fired  = 0;
		keep     = 0;
		if (c.op == stt_pkg::OP_TICK) begin
			// Fire due timers in table order, then compact out the spent ones
			for (int i = 0; i < timer_total; i++) begin
				diff = timer_due[i] - c.now;
				if ((diff == '0 || diff[stt_pkg::TIME_W-1]) && timer_left[i] != '0) begin
					if (timer_left[i] != stt_pkg::ENDLESS)
						timer_left[i] = timer_left[i] - stt_pkg::COUNT_W'(1);
					timer_due[i] = timer_due[i] + stt_pkg::TIME_W'(timer_period[i]);
					fired_tags[n_fired] = timer_tag[i];
					n_fired++;
				end
				if (timer_left[i] != '0) begin
					timer_due[keep]    = timer_due[i];
					timer_period[keep] = timer_period[i];
					timer_left[keep]   = timer_left[i];
					timer_tag[keep]    = timer_tag[i];
					keep++;
				end
			end
			timer_total = keep;
			r.active = stt_pkg::ACTIVE_W'(timer_total);
			if (n_fired == 0)
				report_q = {report_q, r};
			for (int k = 0; k < n_fired; k++) begin
				r.fired = 1'b1;
				r.tag   = fired_tags[k];
				r.last  = (k == n_fired - 1);
				report_q = {report_q, r};
			end
		end else begin
			if (c.op == stt_pkg::OP_ADD) begin
				if (timer_total >= TIMER_SLOTS) begin
					r.status = stt_pkg::ST_FULL;
				end else begin
					timer_due[timer_total]    = c.now + stt_pkg::TIME_W'(c.delay);
					timer_period[timer_total] = c.delay;
					timer_left[timer_total]   = c.count;
					timer_tag[timer_total]    = c.tag;
					timer_total++;
				end
			end else if (c.op == stt_pkg::OP_DELETE) begin
				if (int'(c.pos) >= timer_total) begin
					r.status = stt_pkg::ST_RANGE;
				end else begin
					// Close the gap, keeping the order of the rest
					for (int i = int'(c.pos); i < timer_total - 1; i++) begin
						timer_due[i]    = timer_due[i + 1];
						timer_period[i] = timer_period[i + 1];
						timer_left[i]   = timer_left[i + 1];
						timer_tag[i]    = timer_tag[i + 1];
					end
					timer_total--;
				end
			end
			r.active = stt_pkg::ACTIVE_W'(timer_total);
			report_q = {report_q, r};
		end
	endtask

	// Command driver: bursts of beats with random gaps in between
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= stt_pkg::OP_TICK;
			burst_left = 1;
			gap_left   = 0;
		end else if (!(s_axis_tvalid && !s_axis_tready)) begin
			if (s_axis_tvalid) begin
				run_timer_command(cmd_q.pop_front());
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end
			if (gap_left != 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else if (cmd_q.size() != 0) begin
				cur_cmd = cmd_q[0];
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= {1'b0, cur_cmd.pos, cur_cmd.tag, cur_cmd.count,
					cur_cmd.delay, cur_cmd.now};
				s_axis_tuser  <= cur_cmd.op;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// Result monitor: check each beat, stall on a phased random pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_pct  = 0;
			phase_left = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (report_q.size() == 0) begin
					report_mismatch("unexpected beat", 32'(m_axis_tdata), 32'd0);
				end else begin
					want_beat = report_q.pop_front();
					if (m_axis_tuser !== want_beat.fired)
						report_mismatch("fired", 32'(m_axis_tuser), 32'(want_beat.fired));
					if (m_axis_tdata[15:0] !== want_beat.tag)
						report_mismatch("fired_tag", 32'(m_axis_tdata[15:0]),
							32'(want_beat.tag));
					if (m_axis_tdata[17:16] !== want_beat.status)
						report_mismatch("status", 32'(m_axis_tdata[17:16]),
							32'(want_beat.status));
					if (m_axis_tdata[22:18] !== want_beat.active)
						report_mismatch("active_count", 32'(m_axis_tdata[22:18]),
							32'(want_beat.active));
					if (m_axis_tlast !== want_beat.last)
						report_mismatch("last", 32'(m_axis_tlast), 32'(want_beat.last));
				end
			end
			if (phase_left == 0) begin
				phase_left = $urandom_range(32, 200);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 60;
					default: stall_pct = 90;
				endcase
			end else begin
				phase_left--;
			end
			m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Stimulus and end of run
	initial begin
		logic [stt_pkg::TIME_W-1:0]  now_ms;
		logic [stt_pkg::DELAY_W-1:0] delay;
		logic [stt_pkg::COUNT_W-1:0] count;
		logic [stt_pkg::POS_W-1:0]   pos;
		int                          pick;

		// Empty table, unused code and a delete with nothing held
		add_cmd(stt_pkg::OP_TICK, '0, '0, '0, '0, '0);
		add_cmd(stt_pkg::OP_NONE, '1, '1, '1, '1, '1);
		add_cmd(stt_pkg::OP_DELETE, '0, '0, '0, '0, '0);
		// Longest delay with endless count, zero count, single shot, twice
		add_cmd(stt_pkg::OP_ADD, '0, '1, stt_pkg::ENDLESS, 16'hFFFF, 8'hFF);
		add_cmd(stt_pkg::OP_ADD, '0, '0, '0, 16'h0000, '0);
		add_cmd(stt_pkg::OP_ADD, '0, '0, 32'd1, 16'h1234, '0);
		add_cmd(stt_pkg::OP_ADD, '0, 31'd10, 32'd2, 16'h0005, '0);
		// Due exactly now, zero count dropped, then due across the wrap
		add_cmd(stt_pkg::OP_TICK, '0, '0, '0, '0, '0);
		add_cmd(stt_pkg::OP_TICK, 32'hFFFF_FFFF, '0, '0, '0, '0);
		add_cmd(stt_pkg::OP_TICK, 32'd10, '0, '0, '0, '0);
		// Positions past the end
		add_cmd(stt_pkg::OP_DELETE, '0, '0, '0, '0, 8'hFF);
		add_cmd(stt_pkg::OP_DELETE, '0, '0, '0, '0, 8'd2);
		// Fill the table, overflow it, then fire most of it in one tick
		for (int i = 0; i < 14; i++)
			add_cmd(stt_pkg::OP_ADD, 32'd100, stt_pkg::DELAY_W'(i),
				(i % 3 == 0) ? stt_pkg::ENDLESS : stt_pkg::COUNT_W'(i % 3),
				stt_pkg::TAG_W'(16'hA000 + i), '0);
		add_cmd(stt_pkg::OP_ADD, 32'd100, 31'd5, 32'd1, 16'hBEEF, '0);
		add_cmd(stt_pkg::OP_TICK, 32'd200, '0, '0, '0, '0);
		add_cmd(stt_pkg::OP_DELETE, '0, '0, '0, '0, 8'd0);
		add_cmd(stt_pkg::OP_DELETE, '0, '0, '0, '0, 8'd15);

		// Random traffic, starting just short of the time wrap
		now_ms = 32'hFFFF_FF80;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 38) begin
				case ($urandom_range(0, 9))
					0: delay = stt_pkg::DELAY_W'($urandom);
					1: delay = '0;
					default: delay = stt_pkg::DELAY_W'($urandom_range(1, 40));
				endcase
				case ($urandom_range(0, 9))
					0: count = '0;
					1: count = stt_pkg::ENDLESS;
					2: count = $urandom;
					default: count = $urandom_range(1, 5);
				endcase
				add_cmd(stt_pkg::OP_ADD, now_ms, delay, count,
					stt_pkg::TAG_W'($urandom), stt_pkg::POS_W'($urandom));
			end else if (pick < 78) begin
				if ($urandom_range(0, 19) == 0)
					now_ms = $urandom;
				else
					now_ms = now_ms + $urandom_range(0, 25);
				add_cmd(stt_pkg::OP_TICK, now_ms, stt_pkg::DELAY_W'($urandom), $urandom,
					stt_pkg::TAG_W'($urandom), stt_pkg::POS_W'($urandom));
			end else if (pick < 95) begin
				pos = ($urandom_range(0, 7) == 0) ? stt_pkg::POS_W'($urandom)
					: stt_pkg::POS_W'($urandom_range(0, 16));
				add_cmd(stt_pkg::OP_DELETE, $urandom, stt_pkg::DELAY_W'($urandom), $urandom,
					stt_pkg::TAG_W'($urandom), pos);
			end else begin
				add_cmd(stt_pkg::OP_NONE, $urandom, stt_pkg::DELAY_W'($urandom), $urandom,
					stt_pkg::TAG_W'($urandom), stt_pkg::POS_W'($urandom));
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: all commands taken and every expected beat seen
		while (cmd_q.size() != 0 || s_axis_tvalid || report_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

### filelist.f
hdl/stt_pkg.sv
hdl/stt_entry_ram.sv
hdl/stt_tag_buf.sv
hdl/software_timer_table.sv
dv/software_timer_table_tb.sv
